// ===== src/sssp_pkg.sv =====
package sssp_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;

  localparam int NIDX_W  = $clog2(MAX_NODES);
  localparam int EADDR_W = $clog2(MAX_EDGES);
  localparam int FILL_W  = EADDR_W + 1;
  localparam int CNT_W   = 7;
  localparam int W_W     = 16;
  localparam int DIST_W  = 23;
  localparam int DOUT_W  = 22;
  localparam int HOP_W   = 6;

  localparam logic [CNT_W-1:0]  NODE_COUNT_RESET = 7'd64;
  localparam logic [DOUT_W-1:0] DIST_MAX         = 22'h3FFFFF;
  localparam logic [HOP_W-1:0]  HOPS_MAX         = 6'h3f;

  typedef struct packed {
    logic [NIDX_W-1:0] a;
    logic [NIDX_W-1:0] b;
    logic [W_W-1:0]    w;
  } edge_t;

  typedef struct packed {
    logic [DIST_W-1:0] path_len;
    logic [CNT_W-1:0]  pred;
    logic [HOP_W-1:0]  hop;
  } node_t;

  typedef struct packed {
    logic in_rdy;
    logic init;
    logic sel_clr;
    logic sel_step;
    logic sel_stop;
    logic settle;
    logic e_clr;
    logic e_chk;
    logic n_upd;
    logic o_clr;
    logic o_show;
    logic o_next;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic sel_end;
    logic found;
    logic e_end;
    logic e_need;
    logic out_fire;
    logic o_end;
  } sts_t;

endpackage

// ===== src/sssp_edge_if.sv =====
interface sssp_edge_if;
  logic       valid;
  logic       ready;
  logic [6:0] endpoint_a;
  logic [6:0] endpoint_b;
  logic [15:0] weight;
  logic       last_edge;

  modport source (output valid, endpoint_a, endpoint_b, weight, last_edge, input ready);
  modport sink   (input valid, endpoint_a, endpoint_b, weight, last_edge, output ready);
endinterface

// ===== src/sssp_res_if.sv =====
interface sssp_res_if;
  logic        valid;
  logic        ready;
  logic [6:0]  node;
  logic [21:0] distance;
  logic [6:0]  parent;
  logic [5:0]  hops;
  logic        reachable;
  logic        edges_dropped;
  logic        last;

  modport source (output valid, node, distance, parent, hops, reachable, edges_dropped, last,
                  input ready);
  modport sink   (input valid, node, distance, parent, hops, reachable, edges_dropped, last,
                  output ready);
endinterface

// ===== src/sssp_ram.sv =====
module sssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/sssp_ctrl.sv =====
module sssp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sssp_pkg::sts_t sts_i,
  output sssp_pkg::cmd_t cmd_o
);
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INIT  = 4'd1;
  localparam logic [3:0] ST_SEL   = 4'd2;
  localparam logic [3:0] ST_SELW  = 4'd3;
  localparam logic [3:0] ST_SDEC  = 4'd4;
  localparam logic [3:0] ST_EREQ  = 4'd5;
  localparam logic [3:0] ST_ECHK  = 4'd6;
  localparam logic [3:0] ST_NUPD  = 4'd7;
  localparam logic [3:0] ST_ORD   = 4'd8;
  localparam logic [3:0] ST_OLD   = 4'd9;
  localparam logic [3:0] ST_OSHOW = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_rdy = 1'b1;
        if (sts_i.in_fire && sts_i.in_last) state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_SEL;
      end
      ST_SEL: begin
        cmd_o.sel_step = 1'b1;
        if (sts_i.sel_end) state_d = ST_SELW;
      end
      ST_SELW: begin
        cmd_o.sel_stop = 1'b1;
        state_d        = ST_SDEC;
      end
      ST_SDEC: begin
        if (sts_i.found) begin
          cmd_o.settle = 1'b1;
          cmd_o.e_clr  = 1'b1;
          state_d      = ST_EREQ;
        end else begin
          cmd_o.o_clr = 1'b1;
          state_d     = ST_ORD;
        end
      end
      ST_EREQ: begin
        if (sts_i.e_end) begin
          cmd_o.sel_clr = 1'b1;
          state_d       = ST_SEL;
        end else begin
          state_d = ST_ECHK;
        end
      end
      ST_ECHK: begin
        cmd_o.e_chk = 1'b1;
        state_d     = sts_i.e_need ? ST_NUPD : ST_EREQ;
      end
      ST_NUPD: begin
        cmd_o.n_upd = 1'b1;
        state_d     = ST_EREQ;
      end
      ST_ORD: begin
        state_d = ST_OLD;
      end
      ST_OLD: begin
        cmd_o.o_show = 1'b1;
        state_d      = ST_OSHOW;
      end
      ST_OSHOW: begin
        if (sts_i.out_fire) begin
          if (sts_i.o_end) begin
            cmd_o.done = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            cmd_o.o_next = 1'b1;
            state_d      = ST_ORD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// ===== src/sssp_dp.sv =====
module sssp_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sssp_pkg::CNT_W-1:0]  cfg_wdata_i,
  sssp_edge_if.sink                   edge_i,
  sssp_res_if.source                  res_o,
  input  sssp_pkg::cmd_t              cmd_i,
  output sssp_pkg::sts_t              sts_o
);
  localparam int NW = sssp_pkg::NIDX_W;
  localparam int CW = sssp_pkg::CNT_W;
  localparam int DW = sssp_pkg::DIST_W;
  localparam int HW = sssp_pkg::HOP_W;

  logic [CW-1:0] node_count_q;
  logic [CW-1:0] cnt;
  logic [NW-1:0] last_idx;

  logic [sssp_pkg::FILL_W-1:0] fill_q, e_q;
  logic drop_q;
  logic [sssp_pkg::MAX_NODES-1:0] touched_q, settled_q;

  logic [NW-1:0] idx_q, cmp_idx_q, u_q, v_q, v_d;
  logic          cmp_vld_q, found_q;
  logic [DW-1:0] ud_q;
  logic [HW-1:0] uh_q;
  logic [sssp_pkg::W_W-1:0] w_q;

  sssp_pkg::edge_t e_wdata, e_rdata;
  sssp_pkg::node_t n_wdata, n_rdata;
  logic            e_we, n_we;
  logic [NW-1:0]   n_waddr, n_raddr;

  logic in_fire, in_ok;
  logic [CW-1:0] a_m1, b_m1;
  logic e_bad, hit_a, hit_b;
  logic [CW-1:0] na, nb;
  logic cand_ok;
  logic [DW-1:0] cand;
  logic better;
  logic out_vld_q;

  // Effective node count: zero acts as one, large values clamp.
  always_comb begin
    if (node_count_q == '0) begin
      cnt = CW'(1);
    end else if (node_count_q > CW'(sssp_pkg::MAX_NODES)) begin
      cnt = CW'(sssp_pkg::MAX_NODES);
    end else begin
      cnt = node_count_q;
    end
  end
  assign last_idx = NW'(cnt - CW'(1));

  assign edge_i.ready = cmd_i.in_rdy;
  assign in_fire      = edge_i.valid && edge_i.ready;
  assign in_ok = (edge_i.endpoint_a != '0) && (edge_i.endpoint_b != '0) &&
                 (edge_i.endpoint_a <= cnt) && (edge_i.endpoint_b <= cnt) &&
                 (fill_q < sssp_pkg::FILL_W'(sssp_pkg::MAX_EDGES));
  assign a_m1 = edge_i.endpoint_a - CW'(1);
  assign b_m1 = edge_i.endpoint_b - CW'(1);
  assign e_we = in_fire && in_ok;
  assign e_wdata = '{a: a_m1[NW-1:0], b: b_m1[NW-1:0], w: edge_i.weight};

  sssp_ram #(.WIDTH($bits(sssp_pkg::edge_t)), .DEPTH(sssp_pkg::MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (fill_q[sssp_pkg::EADDR_W-1:0]),
    .wdata_i (e_wdata),
    .raddr_i (e_q[sssp_pkg::EADDR_W-1:0]),
    .rdata_o (e_rdata)
  );

  // Edge check: stored edge against the node being settled.
  assign na    = CW'(e_rdata.a) + CW'(1);
  assign nb    = CW'(e_rdata.b) + CW'(1);
  assign e_bad = (na > cnt) || (nb > cnt);
  assign hit_a = !e_bad && (e_rdata.a == u_q);
  assign hit_b = !e_bad && (e_rdata.b == u_q);
  assign v_d   = hit_a ? e_rdata.b : e_rdata.a;

  always_comb begin
    n_raddr = idx_q;
    if (cmd_i.e_chk) n_raddr = v_d;
  end

  assign cand   = ud_q + DW'(w_q);
  assign better = !touched_q[v_q] || (cand < n_rdata.path_len);

  always_comb begin
    n_we    = 1'b0;
    n_waddr = v_q;
    n_wdata = '{path_len: cand, pred: CW'(u_q) + CW'(1),
                hop: (uh_q == sssp_pkg::HOPS_MAX) ? uh_q : uh_q + HW'(1)};
    if (cmd_i.init) begin
      n_we    = 1'b1;
      n_waddr = '0;
      n_wdata = '0;
    end else if (cmd_i.n_upd && better) begin
      n_we = 1'b1;
    end
  end

  sssp_ram #(.WIDTH($bits(sssp_pkg::node_t)), .DEPTH(sssp_pkg::MAX_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  assign cand_ok = cmp_vld_q && touched_q[cmp_idx_q] && !settled_q[cmp_idx_q] &&
                   (!found_q || (n_rdata.path_len < ud_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= sssp_pkg::NODE_COUNT_RESET;
      fill_q       <= '0;
      drop_q       <= 1'b0;
      touched_q    <= '0;
      settled_q    <= '0;
      idx_q        <= '0;
      cmp_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      e_q          <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) node_count_q <= cfg_wdata_i;
      if (in_fire) begin
        if (in_ok) fill_q <= fill_q + sssp_pkg::FILL_W'(1);
        else       drop_q <= 1'b1;
      end
      if (cmd_i.init) begin
        // Only node one starts out reached.
        touched_q <= sssp_pkg::MAX_NODES'(1);
        settled_q <= '0;
      end
      if (cmd_i.init || cmd_i.sel_clr || cmd_i.o_clr) begin
        idx_q     <= '0;
        cmp_vld_q <= 1'b0;
        found_q   <= 1'b0;
      end
      if (cmd_i.sel_step) begin
        idx_q     <= idx_q + NW'(1);
        cmp_vld_q <= 1'b1;
      end
      if (cmd_i.sel_stop) cmp_vld_q <= 1'b0;
      if (cand_ok) found_q <= 1'b1;
      if (cmd_i.settle) settled_q[u_q] <= 1'b1;
      if (cmd_i.e_clr) e_q <= '0;
      if (cmd_i.e_chk) begin
        e_q <= e_q + sssp_pkg::FILL_W'(1);
        if (e_bad) drop_q <= 1'b1;
      end
      if (cmd_i.n_upd && better) touched_q[v_q] <= 1'b1;
      if (cmd_i.o_show) out_vld_q <= 1'b1;
      if (sts_o.out_fire) out_vld_q <= 1'b0;
      if (cmd_i.o_next) idx_q <= idx_q + NW'(1);
      if (cmd_i.done) begin
        fill_q <= '0;
        drop_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel_step) cmp_idx_q <= idx_q;
    if (cand_ok) begin
      u_q  <= cmp_idx_q;
      ud_q <= n_rdata.path_len;
      uh_q <= n_rdata.hop;
    end
    if (cmd_i.e_chk) begin
      v_q <= v_d;
      w_q <= e_rdata.w;
    end
    if (cmd_i.o_show) begin
      res_o.node      <= CW'(idx_q) + CW'(1);
      res_o.reachable <= touched_q[idx_q];
      res_o.last      <= (idx_q == last_idx);
      res_o.edges_dropped <= drop_q;
      if (touched_q[idx_q]) begin
        res_o.distance <= (n_rdata.path_len > DW'(sssp_pkg::DIST_MAX)) ? sssp_pkg::DIST_MAX
                          : n_rdata.path_len[sssp_pkg::DOUT_W-1:0];
        res_o.parent   <= n_rdata.pred;
        res_o.hops     <= n_rdata.hop;
      end else begin
        res_o.distance <= '0;
        res_o.parent   <= '0;
        res_o.hops     <= '0;
      end
    end
  end

  assign res_o.valid = out_vld_q;

  assign sts_o.in_fire  = in_fire;
  assign sts_o.in_last  = edge_i.last_edge;
  assign sts_o.sel_end  = (idx_q == last_idx);
  assign sts_o.found    = found_q;
  assign sts_o.e_end    = (e_q == fill_q);
  assign sts_o.e_need   = hit_a ^ hit_b;
  assign sts_o.out_fire = out_vld_q && res_o.ready;
  assign sts_o.o_end    = (idx_q == last_idx);
endmodule

// ===== src/single_source_shortest_path_tree_core.sv =====
// Shortest path tree engine rooted at node one.
// Edges arrive on edge_i, one beat per edge, and in-range edges are written
// into the edge memory in load order at one beat per cycle while it has room.
// The beat with last_edge set is stored like the others and then starts the
// search; edge_i.ready stays low until every result of that search is taken.
// Each search round first walks the node memory, one node per cycle, to pick
// the unsettled reachable node with the smallest distance, then scans all
// stored edges, with an extra update step for each edge that touches the
// chosen node. Results leave on res_o, one beat per node in node order; a
// stalled receiver simply holds the beat, which stays stable until taken.
// The result marked last ends the graph and the edge memory is then treated
// as empty.
// Reset clears the fill count, the dropped flag and the controller, and sets
// node_count to 64; node_count is written through cfg_we_i / cfg_wdata_i
// while the block is idle, a rule for the user that the block does not enforce.
module single_source_shortest_path_tree_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sssp_pkg::CNT_W-1:0] cfg_wdata_i,
  sssp_edge_if.sink                  edge_i,
  sssp_res_if.source                 res_o
);
  // Commands from the sequencer and status back from the datapath.
  sssp_pkg::cmd_t cmd;
  sssp_pkg::sts_t sts;

  sssp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // The datapath owns both memories, the per-node flags and the output beat.
  sssp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .edge_i      (edge_i),
    .res_o       (res_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );
endmodule

// ===== src/sssp_chk.sv =====
module sssp_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] node,
  input logic [21:0] distance,
  input logic [6:0] parent,
  input logic [5:0] hops,
  input logic       reachable
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(node) && $stable(distance))
    else $error("stalled result beat changed");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  a_unreach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !reachable |-> distance == '0 && parent == '0 && hops == '0)
    else $error("unreachable node carries path data");

  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && node == 7'd1 |-> reachable && distance == '0 && parent == '0 && hops == '0)
    else $error("root result wrong");
endmodule

bind single_source_shortest_path_tree_core sssp_chk u_sssp_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (edge_i.ready),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .node      (res_o.node),
  .distance  (res_o.distance),
  .parent    (res_o.parent),
  .hops      (res_o.hops),
  .reachable (res_o.reachable)
);
